>>> sv/sv39pte_pkg.sv
// ----------------------------------------------------------------------------
// sv39pte_pkg
// Shared types and constants for the Sv39 page table engine.
// ----------------------------------------------------------------------------
package sv39pte_pkg;

	localparam int TABLE_PAGES_DEF = 16;
	localparam int PT_ENTRIES      = 512;
	localparam int VPN_W           = 9;
	localparam int OFF_W           = 12;
	localparam int FLAG_W          = 10;
	localparam int PPN_W           = 44;
	localparam int VA_W            = 39;
	localparam int PA_W            = 56;
	localparam int PTE_W           = 54;
	localparam int ST_W            = 3;
	localparam int CFG_W           = 44;
	localparam int CFG_IDX_W       = 1;

	localparam logic [VA_W-1:0] USER_LIMIT_RST = 39'h00_8000_0000;

	typedef enum logic [1:0] {
		CMD_MAP   = 2'd0,
		CMD_UNMAP = 2'd1,
		CMD_XLATE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK         = 3'd0,
		ST_UNALIGNED  = 3'd1,
		ST_OOM        = 3'd2,
		ST_NOT_MAPPED = 3'd3,
		ST_KERNEL     = 3'd4,
		ST_NO_PERM    = 3'd5,
		ST_BAD_TABLE  = 3'd6,
		ST_TOO_HIGH   = 3'd7
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_BASE = 1'b0,
		CFG_USER_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_SWEEP,
		S_LINK,
		S_DONE
	} walk_state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [VA_W-1:0]   virt_addr;
		logic [PA_W-1:0]   phys_addr;
		logic [FLAG_W-1:0] pte_flags;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [PA_W-1:0]  result_addr;
		logic [PTE_W-1:0] leaf_entry;
	} rsp_t;

	typedef struct packed {
		logic [PPN_W-1:0] table_base_ppn;
		logic [VA_W-1:0]  user_limit;
	} cfg_t;

endpackage

>>> sv/sv39pte_chan_if.sv
// ----------------------------------------------------------------------------
// sv39pte_chan_if
// Valid/ready channel carrying one item of payload_t.
// ----------------------------------------------------------------------------
interface sv39pte_chan_if #(parameter type payload_t = logic) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

>>> sv/sv39_page_table_engine.sv
// ----------------------------------------------------------------------------
// sv39_page_table_engine
// Sv39 page table store with map, unmap and translate requests.
// Early rejects go from S_CHECK straight to S_DONE; a full walk does three
// dependent table reads (S_READ, S_EVAL per level). Each table allocation adds
// S_LINK, after an S_SWEEP pass that clears the 512 entries of the new page
// when an unallocated page was written earlier. One item at a time: ready
// again in S_IDLE once the result is registered; S_DONE holds on a stall.
// Reset: a pass clears all TABLE_PAGES*512 entries, input not ready meanwhile.
// ----------------------------------------------------------------------------
module sv39_page_table_engine import sv39pte_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	sv39pte_chan_if.sink         req,
	sv39pte_chan_if.source       rsp
);

	localparam int AW = $clog2(TABLE_PAGES * PT_ENTRIES);

	cfg_t             cfg_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [PTE_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [PTE_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_base_ppn <= '0;
			cfg_q.user_limit     <= USER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TABLE_BASE: cfg_q.table_base_ppn <= cfg_wdata[PPN_W-1:0];
				CFG_USER_LIMIT: cfg_q.user_limit     <= cfg_wdata[VA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sv39pte_walk #(.TABLE_PAGES(TABLE_PAGES)) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sv39pte_store #(.TABLE_PAGES(TABLE_PAGES)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

>>> sv/sv39pte_store.sv
// ----------------------------------------------------------------------------
// sv39pte_store
// Table page store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sv39pte_store import sv39pte_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2(TABLE_PAGES*PT_ENTRIES)-1:0]   waddr,
	input  logic [PTE_W-1:0]                            wdata,
	input  logic [$clog2(TABLE_PAGES*PT_ENTRIES)-1:0]   raddr,
	output logic [PTE_W-1:0]                            rdata
);

	localparam int DEPTH = TABLE_PAGES * PT_ENTRIES;

	logic [PTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> sv/sv39pte_walk.sv
// ----------------------------------------------------------------------------
// sv39pte_walk
// Request sequencer: checks, three-level walk, table allocation, result.
// ----------------------------------------------------------------------------
module sv39pte_walk import sv39pte_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  cfg_t                                        cfg,
	sv39pte_chan_if.sink                                req,
	sv39pte_chan_if.source                              rsp,
	output logic                                        mem_we,
	output logic [$clog2(TABLE_PAGES*PT_ENTRIES)-1:0]   mem_waddr,
	output logic [PTE_W-1:0]                            mem_wdata,
	output logic [$clog2(TABLE_PAGES*PT_ENTRIES)-1:0]   mem_raddr,
	input  logic [PTE_W-1:0]                            mem_rdata
);

	localparam int DEPTH = TABLE_PAGES * PT_ENTRIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW - VPN_W;
	localparam int NW    = $clog2(TABLE_PAGES + 1);

	walk_state_t       state_q, state_d;
	logic [1:0]        cmd_q;
	logic [VA_W-1:0]   va_q;
	logic [PPN_W-1:0]  pa_ppn_q;
	logic              pa_off_q;
	logic [FLAG_W-1:0] flags_q;
	logic [1:0]        level_q, level_d;
	logic [PW-1:0]     page_q, page_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [NW-1:0]     nfp_q, nfp_d;
	logic              dirty_q, dirty_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	rsp_t              res_q, res_d;
	rsp_t              out_q;
	logic              out_valid_q;
	logic              accept;
	logic              out_load;

	logic [PPN_W:0]    diff;
	logic              follow_ok;
	logic              store_full;
	logic              page_fresh;
	logic [PTE_W-1:0]  leaf_new;
	logic [1:0]        level_dn;

	function automatic logic [VPN_W-1:0] vpn_at(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [VPN_W-1:0] v;
		case (lvl)
			2'd2:    v = va[38:30];
			2'd1:    v = va[29:21];
			default: v = va[20:12];
		endcase
		return v;
	endfunction

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;
	assign mem_raddr   = pos_q;

	assign diff       = {1'b0, mem_rdata[PTE_W-1:10]} - {1'b0, cfg.table_base_ppn};
	assign follow_ok  = !diff[PPN_W] && (diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
	assign store_full = (nfp_q == NW'(TABLE_PAGES));
	assign page_fresh = (NW'(page_q) >= nfp_q);
	assign leaf_new   = {pa_ppn_q, flags_q[FLAG_W-1:1], 1'b1};
	assign level_dn   = 2'(level_q - 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			nfp_q       <= NW'(1);
			dirty_q     <= 1'b0;
			cnt_q       <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nfp_q   <= nfp_d;
			dirty_q <= dirty_d;
			cnt_q   <= cnt_d;
			level_q <= level_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.payload.command;
			va_q     <= req.payload.virt_addr;
			pa_ppn_q <= req.payload.phys_addr[PA_W-1:OFF_W];
			pa_off_q <= |req.payload.phys_addr[OFF_W-1:0];
			flags_q  <= req.payload.pte_flags;
		end
		page_q <= page_d;
		pos_q  <= pos_d;
		res_q  <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		page_d    = page_q;
		pos_d     = pos_q;
		nfp_d     = nfp_q;
		dirty_d   = dirty_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = '0;

		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				cnt_d     = AW'(cnt_q + 1'b1);
				if (cnt_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				res_d   = '0;
				level_d = 2'd2;
				page_d  = '0;
				pos_d   = {PW'(0), va_q[38:30]};
				state_d = S_READ;
				case (cmd_q)
					CMD_NONE: begin
						state_d = S_DONE;
					end
					CMD_XLATE: begin
						if (va_q >= cfg.user_limit) begin
							res_d.status = ST_KERNEL;
							state_d      = S_DONE;
						end else if (va_q[VA_W-1]) begin
							res_d.status = ST_TOO_HIGH;
							state_d      = S_DONE;
						end
					end
					default: begin
						if ((|va_q[OFF_W-1:0]) || (cmd_q == CMD_MAP && pa_off_q)) begin
							res_d.status = ST_UNALIGNED;
							state_d      = S_DONE;
						end
					end
				endcase
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_DONE;
				if (level_q != 2'd0) begin
					if (!mem_rdata[0]) begin
						if (cmd_q != CMD_MAP) begin
							res_d.status = ST_NOT_MAPPED;
						end else if (store_full) begin
							res_d.status = ST_OOM;
						end else begin
							cnt_d   = '0;
							state_d = dirty_q ? S_SWEEP : S_LINK;
						end
					end else if (follow_ok) begin
						page_d  = diff[PW-1:0];
						level_d = level_dn;
						pos_d   = {diff[PW-1:0], vpn_at(va_q, level_dn)};
						state_d = S_READ;
					end else begin
						res_d.status = ST_BAD_TABLE;
					end
				end else begin
					case (cmd_q)
						CMD_MAP: begin
							mem_we           = 1'b1;
							mem_wdata        = leaf_new;
							res_d.leaf_entry = leaf_new;
							if (page_fresh) begin
								dirty_d = 1'b1;
							end
						end
						CMD_UNMAP: begin
							mem_we           = 1'b1;
							res_d.leaf_entry = mem_rdata;
						end
						CMD_XLATE: begin
							if (!mem_rdata[0]) begin
								res_d.status = ST_NOT_MAPPED;
							end else begin
								res_d.leaf_entry = mem_rdata;
								if (mem_rdata[3:1] == 3'b000) begin
									res_d.status = ST_NO_PERM;
								end else begin
									res_d.result_addr = {mem_rdata[PTE_W-1:10],
										va_q[OFF_W-1:0]};
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = {nfp_q[PW-1:0], cnt_q[VPN_W-1:0]};
				cnt_d     = AW'(cnt_q + 1'b1);
				if (cnt_q[VPN_W-1:0] == VPN_W'(PT_ENTRIES - 1)) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_wdata = {PPN_W'(cfg.table_base_ppn + PPN_W'(nfp_q)), 9'd0, 1'b1};
				nfp_d     = NW'(nfp_q + 1'b1);
				if (page_fresh) begin
					dirty_d = 1'b1;
				end
				state_d = S_READ;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
